FILE: rtl/core/fsra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fsra_pkg;
  localparam int unsigned SLOTS   = 1024;
  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned BIT_W   = 5;
  localparam int unsigned WORDS   = SLOTS / WORD_W;
  localparam int unsigned WADDR_W = SLOT_W - BIT_W;
  localparam int unsigned PC_W    = BIT_W + 1;

  localparam logic [1:0] ST_PLACED  = 2'd0;
  localparam logic [1:0] ST_NOFREE  = 2'd1;
  localparam logic [1:0] ST_CLEARED = 2'd2;

  localparam logic CMD_PLACE = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic [WORD_W-1:0] wdata;
    logic [PC_W-1:0]   cnt;
    logic              any;
    logic [BIT_W-1:0]  lo_bit;
    logic [BIT_W-1:0]  hi_bit;
  } word_res_t;
endpackage
`default_nettype wire

FILE: rtl/core/free_slot_run_allocator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// a command rejected up front goes straight to the result; otherwise the core scans
// 32-slot bitmap words (at most 32), one word per cycle through the bitmap
// read-modify-write; one command in flight, the next command is accepted once the
// result loads into the output register, held off while an earlier result waits unaccepted
// reset: asynchronous active low, bitmap reads as all empty through per-word
// valid bits, num_slots returns to 1024, no clearing pass
module free_slot_run_allocator_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [fsra_pkg::CNT_W-1:0]   cfg_num_slots_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         cmd_i,
  input  wire logic [fsra_pkg::SLOT_W-1:0]  start_slot_i,
  input  wire logic [fsra_pkg::CNT_W-1:0]   amount_or_end_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [1:0]                        status_o,
  output logic [fsra_pkg::SLOT_W-1:0]       first_slot_o,
  output logic [fsra_pkg::SLOT_W-1:0]       last_slot_o,
  output logic [fsra_pkg::CNT_W-1:0]        freed_count_o
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                      state_q, state_d;
  logic [fsra_pkg::CNT_W-1:0]      nslots_q;
  logic [fsra_pkg::WORDS-1:0]      vld_q;
  logic                            cmd_q;
  logic [fsra_pkg::SLOT_W-1:0]     lo_q, hi_q;
  logic [fsra_pkg::WADDR_W-1:0]    rw_q, pw_q, lastw_q;
  logic                            pv_q;
  logic [fsra_pkg::CNT_W-1:0]      rem_q, freed_q;
  logic                            any_q;
  logic [fsra_pkg::SLOT_W-1:0]     first_q, last_q;
  logic                            ov_q;
  logic [1:0]                      ost_q;
  logic [fsra_pkg::SLOT_W-1:0]     ofirst_q, olast_q;
  logic [fsra_pkg::CNT_W-1:0]      ofreed_q;

  logic [fsra_pkg::CNT_W-1:0]      n_act, n_m1, want;
  logic                            reject, in_xfer, done_w;
  logic [fsra_pkg::SLOT_W-1:0]     hi_new;
  logic [fsra_pkg::WORD_W-1:0]     rdata, data_eff;
  fsra_pkg::word_res_t             wres;
  logic [fsra_pkg::CNT_W-1:0]      cnt_ext;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;

  assign n_act = (nslots_q > fsra_pkg::CNT_W'(fsra_pkg::SLOTS)) ?
                 fsra_pkg::CNT_W'(fsra_pkg::SLOTS) : nslots_q;
  assign n_m1  = n_act - fsra_pkg::CNT_W'(1);
  assign want  = (amount_or_end_i == '0) ? fsra_pkg::CNT_W'(1) : amount_or_end_i;

  always_comb begin
    reject = (n_act == '0) || ({1'b0, start_slot_i} >= n_act);
    hi_new = n_m1[fsra_pkg::SLOT_W-1:0];
    if (cmd_i == fsra_pkg::CMD_CLEAR) begin
      if ({1'b0, start_slot_i} > amount_or_end_i) begin
        reject = 1'b1;
      end
      if (amount_or_end_i < n_m1) begin
        hi_new = amount_or_end_i[fsra_pkg::SLOT_W-1:0];
      end
    end
  end

  fsra_ram #(.W(fsra_pkg::WORD_W), .D(fsra_pkg::WORDS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (pv_q),
    .waddr_i (pw_q),
    .wdata_i (wres.wdata),
    .raddr_i (rw_q),
    .rdata_o (rdata)
  );

  assign data_eff = vld_q[pw_q] ? rdata : '0;

  fsra_word u_word (
    .cmd_i  (cmd_q),
    .data_i (data_eff),
    .word_i (pw_q),
    .lo_i   (lo_q),
    .hi_i   (hi_q),
    .rem_i  (rem_q),
    .res_o  (wres)
  );

  assign cnt_ext = fsra_pkg::CNT_W'(wres.cnt);
  assign done_w  = pv_q && ((pw_q == lastw_q) ||
                   ((cmd_q == fsra_pkg::CMD_PLACE) && (rem_q == cnt_ext)));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = reject ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (done_w) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!ov_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      nslots_q <= fsra_pkg::CNT_W'(fsra_pkg::SLOTS);
      vld_q    <= '0;
      pv_q     <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        nslots_q <= cfg_num_slots_i;
      end
      if (pv_q) begin
        vld_q[pw_q] <= 1'b1;
      end
      pv_q <= (state_q == S_SCAN) && !done_w;
      if (state_q == S_DONE && (!ov_q || out_ready_i)) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q   <= cmd_i;
      lo_q    <= start_slot_i;
      hi_q    <= hi_new;
      lastw_q <= hi_new[fsra_pkg::SLOT_W-1:fsra_pkg::BIT_W];
      rw_q    <= start_slot_i[fsra_pkg::SLOT_W-1:fsra_pkg::BIT_W];
      rem_q   <= want;
      freed_q <= '0;
      any_q   <= 1'b0;
      first_q <= '0;
      last_q  <= '0;
    end else if (state_q == S_SCAN) begin
      rw_q <= rw_q + fsra_pkg::WADDR_W'(1);
      pw_q <= rw_q;
      if (pv_q) begin
        rem_q   <= rem_q - cnt_ext;
        freed_q <= freed_q + cnt_ext;
        if (wres.any) begin
          any_q  <= 1'b1;
          last_q <= {pw_q, wres.hi_bit};
          if (!any_q) begin
            first_q <= {pw_q, wres.lo_bit};
          end
        end
      end
    end
    if (state_q == S_DONE && (!ov_q || out_ready_i)) begin
      ofirst_q <= '0;
      olast_q  <= '0;
      ofreed_q <= '0;
      if (cmd_q == fsra_pkg::CMD_CLEAR) begin
        ost_q    <= fsra_pkg::ST_CLEARED;
        ofreed_q <= freed_q;
      end else if (any_q) begin
        ost_q    <= fsra_pkg::ST_PLACED;
        ofirst_q <= first_q;
        olast_q  <= last_q;
      end else begin
        ost_q <= fsra_pkg::ST_NOFREE;
      end
    end
  end

  assign out_valid_o   = ov_q;
  assign status_o      = ost_q;
  assign first_slot_o  = ofirst_q;
  assign last_slot_o   = olast_q;
  assign freed_count_o = ofreed_q;
endmodule
`default_nettype wire

FILE: rtl/core/fsra_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module fsra_ram #(
  parameter int unsigned W  = 32,
  parameter int unsigned D  = 32,
  parameter int unsigned AW = $clog2(D)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [W-1:0]  wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [W-1:0]  rdata_o
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

FILE: rtl/core/fsra_word.sv
`timescale 1ns / 1ps
`default_nettype none
module fsra_word (
  input  wire logic                            cmd_i,
  input  wire logic [fsra_pkg::WORD_W-1:0]     data_i,
  input  wire logic [fsra_pkg::WADDR_W-1:0]    word_i,
  input  wire logic [fsra_pkg::SLOT_W-1:0]     lo_i,
  input  wire logic [fsra_pkg::SLOT_W-1:0]     hi_i,
  input  wire logic [fsra_pkg::CNT_W-1:0]      rem_i,
  output fsra_pkg::word_res_t                  res_o
);
  logic [fsra_pkg::WORD_W-1:0] mask;
  logic [fsra_pkg::WORD_W-1:0] free;
  logic [fsra_pkg::WORD_W-1:0] take;
  logic [fsra_pkg::WORD_W-1:0] sel;
  logic [fsra_pkg::PC_W-1:0]   pre [fsra_pkg::WORD_W];
  logic                        rem_big;

  assign rem_big = |rem_i[fsra_pkg::CNT_W-1:fsra_pkg::BIT_W];

  always_comb begin
    for (int i = 0; i < fsra_pkg::WORD_W; i++) begin
      mask[i] = ({word_i, i[fsra_pkg::BIT_W-1:0]} >= lo_i) &&
                ({word_i, i[fsra_pkg::BIT_W-1:0]} <= hi_i);
    end
  end

  assign free = ~data_i & mask;

  // free slots below each bit position
  always_comb begin
    for (int i = 0; i < fsra_pkg::WORD_W; i++) begin
      pre[i] = fsra_pkg::PC_W'($countones(free & (((fsra_pkg::WORD_W)'(1) << i)
                                          - (fsra_pkg::WORD_W)'(1))));
      take[i] = free[i] && (rem_big ||
                pre[i] < {1'b0, rem_i[fsra_pkg::BIT_W-1:0]});
    end
  end

  assign sel = (cmd_i == fsra_pkg::CMD_PLACE) ? take : (data_i & mask);

  always_comb begin
    res_o.wdata  = (cmd_i == fsra_pkg::CMD_PLACE) ? (data_i | take) : (data_i & ~sel);
    res_o.cnt    = fsra_pkg::PC_W'($countones(sel));
    res_o.any    = |sel;
    res_o.lo_bit = '0;
    res_o.hi_bit = '0;
    for (int i = fsra_pkg::WORD_W - 1; i >= 0; i--) begin
      if (sel[i]) begin
        res_o.lo_bit = i[fsra_pkg::BIT_W-1:0];
      end
    end
    for (int i = 0; i < fsra_pkg::WORD_W; i++) begin
      if (sel[i]) begin
        res_o.hi_bit = i[fsra_pkg::BIT_W-1:0];
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/fsra_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module fsra_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire logic [1:0]                   status_o,
  input wire logic [fsra_pkg::SLOT_W-1:0]  first_slot_o,
  input wire logic [fsra_pkg::SLOT_W-1:0]  last_slot_o,
  input wire logic [fsra_pkg::CNT_W-1:0]   freed_count_o
);
  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(first_slot_o) && $stable(last_slot_o) && $stable(freed_count_o))
    else $error("result changed while stalled");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("bad status");

  a_nofree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == fsra_pkg::ST_NOFREE |->
    first_slot_o == '0 && last_slot_o == '0 && freed_count_o == '0)
    else $error("failed place with nonzero fields");

  a_placed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == fsra_pkg::ST_PLACED |->
    first_slot_o <= last_slot_o && freed_count_o == '0)
    else $error("bad placed run");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == fsra_pkg::ST_CLEARED |->
    first_slot_o == '0 && last_slot_o == '0 &&
    freed_count_o <= fsra_pkg::CNT_W'(fsra_pkg::SLOTS))
    else $error("bad clear result");
endmodule

bind free_slot_run_allocator_core fsra_checker u_fsra_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_o      (status_o),
  .first_slot_o  (first_slot_o),
  .last_slot_o   (last_slot_o),
  .freed_count_o (freed_count_o)
);
`default_nettype wire

FILE: dv/tb_free_slot_run_allocator_core.sv
`timescale 1ns / 1ps
module tb_free_slot_run_allocator_core;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 40;

  typedef struct packed {
    logic                        cmd;
    logic [fsra_pkg::SLOT_W-1:0] start;
    logic [fsra_pkg::CNT_W-1:0]  arg;
  } alloc_cmd_t;

  typedef struct packed {
    logic [1:0]                  status;
    logic [fsra_pkg::SLOT_W-1:0] first;
    logic [fsra_pkg::SLOT_W-1:0] last;
    logic [fsra_pkg::CNT_W-1:0]  freed;
  } alloc_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [fsra_pkg::CNT_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic cmd = 1'b0;
  logic [fsra_pkg::SLOT_W-1:0] start_slot = '0;
  logic [fsra_pkg::CNT_W-1:0] amount_or_end = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic [fsra_pkg::SLOT_W-1:0] first_slot, last_slot;
  logic [fsra_pkg::CNT_W-1:0] freed_count;

  free_slot_run_allocator_core DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_num_slots_i(cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .cmd_i          (cmd),
    .start_slot_i   (start_slot),
    .amount_or_end_i(amount_or_end),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .first_slot_o   (first_slot),
    .last_slot_o    (last_slot),
    .freed_count_o  (freed_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  logic [fsra_pkg::SLOTS-1:0] slot_busy;
  logic [fsra_pkg::CNT_W-1:0] slots_in_use;
  alloc_cmd_t       cmd_q[$];
  alloc_res_t       result_q[$];
  logic [fsra_pkg::CNT_W-1:0] size_q[$];
  int fails = 0;
  int results_seen = 0;
  int n_place = 0, n_clear = 0, n_nofree = 0;
  bit no_idle = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic alloc_res_t allocate(alloc_cmd_t c);
    alloc_res_t res;
    int n, avail, want, filled, last_s;
    res = '0;
    n = (slots_in_use < fsra_pkg::SLOTS) ? int'(slots_in_use) : fsra_pkg::SLOTS;
    if (c.cmd == fsra_pkg::CMD_PLACE) begin
      avail = 0;
      for (int s = c.start; s < n; s++) if (!slot_busy[s]) avail++;
      if (avail == 0) begin
        res.status = fsra_pkg::ST_NOFREE;
        return res;
      end
      want = (c.arg == 0) ? 1 : int'(c.arg);
      if (want > avail) want = avail;
      filled = 0;
      res.status = fsra_pkg::ST_PLACED;
      for (int s = c.start; s < n && filled < want; s++) begin
        if (!slot_busy[s]) begin
          if (filled == 0) res.first = s[fsra_pkg::SLOT_W-1:0];
          slot_busy[s] = 1'b1;
          res.last = s[fsra_pkg::SLOT_W-1:0];
          filled++;
        end
      end
    end else begin
      res.status = fsra_pkg::ST_CLEARED;
      if (c.start <= c.arg && c.start < n) begin
        last_s = (int'(c.arg) > n - 1) ? n - 1 : int'(c.arg);
        for (int s = c.start; s <= last_s; s++) begin
          if (slot_busy[s]) begin
            slot_busy[s] = 1'b0;
            res.freed = res.freed + 1'b1;
          end
        end
      end
    end
    return res;
  endfunction

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    alloc_cmd_t c;
    alloc_res_t r;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        r = allocate({cmd, start_slot, amount_or_end});
        result_q.push_back(r);
        if (r.status == fsra_pkg::ST_NOFREE) n_nofree++;
        else if (cmd == fsra_pkg::CMD_PLACE) n_place++;
        else n_clear++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          c = cmd_q.pop_front();
          cmd <= c.cmd;
          start_slot <= c.start;
          amount_or_end <= c.arg;
          in_valid <= 1'b1;
          in_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // config writer
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        slots_in_use = cfg_data;
        cfg_valid <= 1'b0;
      end else if (!cfg_valid && size_q.size() > 0) begin
        cfg_data <= size_q.pop_front();
        cfg_valid <= 1'b1;
      end
    end
  end

  // monitor with random backpressure and one long hold
  int out_gap = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    alloc_res_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (result_q.size() == 0) begin
          $display("%0t: unexpected transfer status=%0d first=%0d last=%0d freed=%0d",
                   $time, status, first_slot, last_slot, freed_count);
          fails++;
        end else begin
          e = result_q.pop_front();
          if (status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, status);
            fails++;
          end
          if (first_slot !== e.first) begin
            $display("%0t: first_slot expected %0d actual %0d", $time, e.first, first_slot);
            fails++;
          end
          if (last_slot !== e.last) begin
            $display("%0t: last_slot expected %0d actual %0d", $time, e.last, last_slot);
            fails++;
          end
          if (freed_count !== e.freed) begin
            $display("%0t: freed_count expected %0d actual %0d", $time, e.freed,
                     freed_count);
            fails++;
          end
        end
      end
      if (!hold_done && results_seen == 120) begin
        hold_done <= 1'b1;
        hold_left <= LONG_HOLD;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (out_valid && out_ready) out_gap <= pick_gap();
      end
    end
  end

  // watchdog
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, result_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic add_cmd(logic c, int s, int a);
    alloc_cmd_t item;
    item.cmd = c;
    item.start = s[fsra_pkg::SLOT_W-1:0];
    item.arg = a[fsra_pkg::CNT_W-1:0];
    cmd_q.push_back(item);
  endtask

  task automatic wait_idle();
    while (cmd_q.size() > 0 || in_valid || result_q.size() > 0 || cfg_valid
           || size_q.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_size(int v);
    wait_idle();
    size_q.push_back(v[fsra_pkg::CNT_W-1:0]);
    wait_idle();
  endtask

  task automatic add_random(int count);
    int n, s, a;
    n = (slots_in_use < fsra_pkg::SLOTS) ? int'(slots_in_use) : fsra_pkg::SLOTS;
    repeat (count) begin
      if (n > 0 && $urandom_range(0, 9) < 8) s = $urandom_range(0, n - 1);
      else s = $urandom_range(0, fsra_pkg::SLOTS - 1);
      if ($urandom_range(0, 1) == 0) begin
        a = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 48) : $urandom_range(0, 2047);
        add_cmd(fsra_pkg::CMD_PLACE, s, a);
      end else begin
        a = ($urandom_range(0, 9) < 7) ? s + $urandom_range(0, 64)
                                       : $urandom_range(0, 2047);
        add_cmd(fsra_pkg::CMD_CLEAR, s, a);
      end
    end
  endtask

  initial begin
    int sizes[7];
    slot_busy = '0;
    slots_in_use = fsra_pkg::CNT_W'(fsra_pkg::SLOTS);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    add_cmd(fsra_pkg::CMD_PLACE, 0, 0);
    add_cmd(fsra_pkg::CMD_PLACE, 0, 1024);
    add_cmd(fsra_pkg::CMD_PLACE, 0, 5);
    add_cmd(fsra_pkg::CMD_CLEAR, 5, 2);
    add_cmd(fsra_pkg::CMD_CLEAR, 1023, 1023);
    add_cmd(fsra_pkg::CMD_PLACE, 1023, 2047);
    add_cmd(fsra_pkg::CMD_CLEAR, 10, 20);
    add_cmd(fsra_pkg::CMD_PLACE, 5, 3);
    add_cmd(fsra_pkg::CMD_PLACE, 0, 100);
    add_cmd(fsra_pkg::CMD_CLEAR, 0, 2047);
    add_cmd(fsra_pkg::CMD_PLACE, 1000, 2047);
    wait_idle();
    set_size(0);
    add_cmd(fsra_pkg::CMD_PLACE, 0, 1);
    add_cmd(fsra_pkg::CMD_CLEAR, 0, 1023);
    wait_idle();
    set_size(1);
    add_cmd(fsra_pkg::CMD_PLACE, 0, 4);
    add_cmd(fsra_pkg::CMD_PLACE, 0, 4);
    add_cmd(fsra_pkg::CMD_PLACE, 1, 1);
    add_cmd(fsra_pkg::CMD_CLEAR, 1, 1000);
    add_cmd(fsra_pkg::CMD_CLEAR, 0, 0);
    wait_idle();
    set_size(2047);
    add_cmd(fsra_pkg::CMD_PLACE, 1020, 10);
    add_cmd(fsra_pkg::CMD_CLEAR, 1000, 2047);
    wait_idle();

    // random phases at several sizes
    sizes = '{1024, 100, 2047, 1, 37, 0, 1024};
    foreach (sizes[i]) begin
      set_size(sizes[i]);
      no_idle = (i == 2);
      add_random(sizes[i] <= 1 ? 30 : 115);
      wait_idle();
    end
    no_idle = 1'b0;

    wait_idle();
    if (result_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, result_q.size());
      fails++;
    end
    $display("covered %0d results: %0d placements, %0d full-range rejects, %0d clears",
             results_seen, n_place, n_nofree, n_clear);
    $display("slot counts swept from 0 to 2047 with a long output stall");
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

FILE: sim.f
rtl/core/fsra_pkg.sv
rtl/core/fsra_ram.sv
rtl/core/fsra_word.sv
rtl/core/free_slot_run_allocator_core.sv
rtl/core/fsra_checker.sv
dv/tb_free_slot_run_allocator_core.sv
